[hdl/kst_pkg.sv]
// ----------------------------------------------------------------------------
// kst_pkg
// shared widths, defaults, command codes and controller states
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int unsigned KST_TABLE_DEPTH  = 16;
  localparam int unsigned KST_PAYLOAD_BITS = 32;

  localparam int unsigned KEY_W       = 32;
  localparam int unsigned PAY_W       = 32;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned LIMIT_W     = 5;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_TUSER_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_TAKE     = 3'd2,
    CMD_LOOKUP   = 3'd3,
    CMD_SNAPSHOT = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RESP = 3'b100
  } state_t;

endpackage

[hdl/kst_ram.sv]
// ----------------------------------------------------------------------------
// kst_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module kst_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/keyed_slot_table.sv]
// ----------------------------------------------------------------------------
// keyed_slot_table
// keyed slot table: insert, remove, take, lookup and snapshot of entries
// ----------------------------------------------------------------------------
// sequence: a command is accepted in ST_IDLE, moves to ST_RESP, then loads the
//   output register; a snapshot that returns entries passes ST_SCAN before each ST_RESP
// concurrency: one command in flight; each snapshot entry takes a ram read in
//   ST_SCAN, then the output load in ST_RESP; out_tready stalls hold ST_RESP
// key match and free-slot search run in parallel over the valid flags and keys
// reset: synchronous, clears all valid flags at once, table empty, no sweep
module keyed_slot_table #(
  parameter int unsigned TABLE_DEPTH  = kst_pkg::KST_TABLE_DEPTH,
  parameter int unsigned PAYLOAD_BITS = kst_pkg::KST_PAYLOAD_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // command, key, payload, snapshot_limit
  input  logic [kst_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // entry_key, entry_payload, entry_count, zero fill
  output logic [kst_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status, entry_valid
  output logic [kst_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                            out_tlast
);
  import kst_pkg::*;

  localparam int unsigned IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned RAM_W = KEY_W + PAYLOAD_BITS;

  state_t state_r, state_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r [TABLE_DEPTH];
  logic [IW-1:0] scan_r, scan_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic hold_status_r, hold_status_nxt;
  logic hold_ev_r, hold_ev_nxt;
  logic hold_last_r, hold_last_nxt;
  logic [CNT_W-1:0] hold_cnt_r, hold_cnt_nxt;

  logic out_valid_r;
  logic out_status_r, out_ev_r, out_last_r;
  logic [KEY_W-1:0] out_key_r;
  logic [PAY_W-1:0] out_pay_r;
  logic [CNT_W-1:0] out_cnt_r;

  cmd_t in_cmd;
  logic [KEY_W-1:0] in_key;
  logic [PAY_W-1:0] in_pay;
  logic [LIMIT_W-1:0] in_limit;
  logic [63:0] in_pay_ext;
  logic [63:0] rd_pay_ext;

  logic in_fire, out_free, load_out, key_we, ins_ok;
  logic hit, free_any, snap_found, snap_more;
  logic [IW-1:0] hit_idx, free_idx, snap_idx;
  logic [CNT_W-1:0] cnt_inc;

  logic ram_we, ram_re;
  logic [IW-1:0] ram_raddr;
  logic [RAM_W-1:0] ram_wdata, ram_rdata;

  assign in_cmd     = cmd_t'(in_tdata[2:0]);
  assign in_key     = in_tdata[34:3];
  assign in_pay     = in_tdata[66:35];
  assign in_limit   = in_tdata[71:67];
  assign in_pay_ext = 64'(in_pay);
  assign ram_wdata  = {in_pay_ext[PAYLOAD_BITS-1:0], in_key};
  assign rd_pay_ext = 64'(ram_rdata[RAM_W-1:KEY_W]);

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign load_out  = (state_r == ST_RESP) && out_free;
  assign cnt_inc   = hold_cnt_r + CNT_W'(1);
  assign ins_ok    = in_fire && (in_cmd == CMD_INSERT) && !hit && free_any;

  // key match and lowest free slot
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (valid_r[i] && (key_r[i] == in_key)) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // next valid slot from the scan pointer, and whether another follows
  always_comb begin
    snap_found = 1'b0;
    snap_more  = 1'b0;
    snap_idx   = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (valid_r[i] && (i >= int'(scan_r))) begin
        if (!snap_found) begin
          snap_found = 1'b1;
          snap_idx   = IW'(i);
        end else begin
          snap_more = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    valid_nxt       = valid_r;
    scan_nxt        = scan_r;
    limit_nxt       = limit_r;
    hold_status_nxt = hold_status_r;
    hold_ev_nxt     = hold_ev_r;
    hold_last_nxt   = hold_last_r;
    hold_cnt_nxt    = hold_cnt_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_raddr       = hit_idx;
    key_we          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt       = ST_RESP;
          hold_status_nxt = 1'b1;
          hold_ev_nxt     = 1'b0;
          hold_last_nxt   = 1'b1;
          hold_cnt_nxt    = '0;
          limit_nxt       = in_limit;
          case (in_cmd)
            CMD_INSERT: begin
              if (!hit && free_any) begin
                hold_status_nxt     = 1'b0;
                valid_nxt[free_idx] = 1'b1;
                ram_we              = 1'b1;
                key_we              = 1'b1;
              end
            end
            CMD_REMOVE: begin
              if (hit) begin
                hold_status_nxt    = 1'b0;
                valid_nxt[hit_idx] = 1'b0;
              end
            end
            CMD_TAKE: begin
              if (hit) begin
                hold_status_nxt    = 1'b0;
                hold_ev_nxt        = 1'b1;
                valid_nxt[hit_idx] = 1'b0;
                ram_re             = 1'b1;
              end
            end
            CMD_LOOKUP: begin
              if (hit) begin
                hold_status_nxt = 1'b0;
                hold_ev_nxt     = 1'b1;
                ram_re          = 1'b1;
              end
            end
            CMD_SNAPSHOT: begin
              if (in_limit != '0) begin
                hold_status_nxt = 1'b0;
                if (|valid_r) begin
                  state_nxt = ST_SCAN;
                  scan_nxt  = '0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        ram_re          = 1'b1;
        ram_raddr       = snap_idx;
        hold_status_nxt = 1'b0;
        hold_ev_nxt     = 1'b1;
        hold_cnt_nxt    = cnt_inc;
        hold_last_nxt   = !snap_more || (cnt_inc == limit_r);
        scan_nxt        = snap_idx + IW'(1);
        state_nxt       = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = hold_last_r ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      hold_last_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      hold_last_r <= hold_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r        <= scan_nxt;
    limit_r       <= limit_nxt;
    hold_status_r <= hold_status_nxt;
    hold_ev_r     <= hold_ev_nxt;
    hold_cnt_r    <= hold_cnt_nxt;
    if (key_we) begin
      key_r[free_idx] <= in_key;
    end
  end

  kst_ram #(
    .WIDTH(RAM_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(free_idx),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= hold_status_r;
      out_ev_r     <= hold_ev_r;
      out_last_r   <= hold_last_r;
      out_cnt_r    <= hold_cnt_r;
      out_key_r    <= hold_ev_r ? ram_rdata[KEY_W-1:0] : '0;
      out_pay_r    <= hold_ev_r ? rd_pay_ext[PAY_W-1:0] : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_pay_r, out_key_r};
  assign out_tuser  = {out_ev_r, out_status_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_insert_fills: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |=> ($countones(valid_r) == $past($countones(valid_r)) + 1))
    else $error("insert did not fill exactly one slot");

  a_scan_finds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> snap_found)
    else $error("snapshot scan without a valid slot");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second command accepted while one is in flight");

  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> !out_tuser[0])
    else $error("returned entry with failure status");
`endif

endmodule
